// ----- hdl/seg_isect_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types and orientation codes for the segment intersection test.
// This package has no dependencies.
package seg_isect_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int SumWidth   = ProdWidth + 1;
  localparam int NumTests   = 4;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  typedef enum logic [2:0] {
    TURN_CCW   = 3'd0,
    TURN_CW    = 3'd1,
    TURN_BACK  = 3'd2,
    TURN_FRONT = 3'd3,
    TURN_ON    = 3'd4
  } turn_e;

  // True when the signed weight of a code is positive (ccw or back).
  function automatic logic turn_positive(input turn_e code);
    return code inside {TURN_CCW, TURN_BACK};
  endfunction

  // One segment's test passes when the other segment's endpoints do not lie
  // strictly on the same side by weight sign, or either one lies on it.
  function automatic logic pair_straddles(input turn_e c0, input turn_e c1);
    return (c0 == TURN_ON) || (c1 == TURN_ON) || (turn_positive(c0) != turn_positive(c1));
  endfunction

endpackage

// ----- hdl/segment_intersection_test.sv -----
`timescale 1ns / 1ps
// Top level of the segment intersection test: a five-stage pipeline of
// differences, products, sums, comparisons and the final meet decision.
// Depends on seg_isect_pkg.
// Throughput is one request per cycle; the whole pipeline holds while the
// output register is full and not taken, so in_ready_o follows out_ready_i.
// Reset clears all stage valid bits asynchronously; payload registers are not reset.
module segment_intersection_test (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  seg_isect_pkg::coord_t        seg_a_start_x_i,
  input  seg_isect_pkg::coord_t        seg_a_start_y_i,
  input  seg_isect_pkg::coord_t        seg_a_end_x_i,
  input  seg_isect_pkg::coord_t        seg_a_end_y_i,
  input  seg_isect_pkg::coord_t        seg_b_start_x_i,
  input  seg_isect_pkg::coord_t        seg_b_start_y_i,
  input  seg_isect_pkg::coord_t        seg_b_end_x_i,
  input  seg_isect_pkg::coord_t        seg_b_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         segments_meet_o,
  output logic [2:0]                   turn_a_bstart_o,
  output logic [2:0]                   turn_a_bend_o,
  output logic [2:0]                   turn_b_astart_o,
  output logic [2:0]                   turn_b_aend_o
);

  localparam int N = seg_isect_pkg::NumTests;

  logic advance;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  seg_isect_pkg::diff_t ux_d [N], uy_d [N], vx_d [N], vy_d [N];
  seg_isect_pkg::diff_t ux_q [N], uy_q [N], vx_q [N], vy_q [N];

  seg_isect_pkg::prod_t lhs_d [N], rhs_d [N], dxx_d [N], dyy_d [N];
  seg_isect_pkg::prod_t uxx_d [N], uyy_d [N], vxx_d [N], vyy_d [N];
  seg_isect_pkg::prod_t lhs_q [N], rhs_q [N], dxx_q [N], dyy_q [N];
  seg_isect_pkg::prod_t uxx_q [N], uyy_q [N], vxx_q [N], vyy_q [N];

  seg_isect_pkg::sum_t cross_d [N], dot_d [N], lu_d [N], lv_d [N];
  seg_isect_pkg::sum_t cross_q [N], dot_q [N], lu_q [N], lv_q [N];

  seg_isect_pkg::turn_e code_d [N];
  seg_isect_pkg::turn_e code_q [N];

  logic                 meet_d, meet_q;
  seg_isect_pkg::turn_e out_code_q [N];

  assign advance    = !v5_q || out_ready_i;
  assign in_ready_o = advance;

  always_comb begin
    seg_isect_pkg::diff_t sx [N], sy [N], ex [N], ey [N], px [N], py [N];
    seg_isect_pkg::diff_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    ax0 = seg_isect_pkg::diff_t'(seg_a_start_x_i);
    ay0 = seg_isect_pkg::diff_t'(seg_a_start_y_i);
    ax1 = seg_isect_pkg::diff_t'(seg_a_end_x_i);
    ay1 = seg_isect_pkg::diff_t'(seg_a_end_y_i);
    bx0 = seg_isect_pkg::diff_t'(seg_b_start_x_i);
    by0 = seg_isect_pkg::diff_t'(seg_b_start_y_i);
    bx1 = seg_isect_pkg::diff_t'(seg_b_end_x_i);
    by1 = seg_isect_pkg::diff_t'(seg_b_end_y_i);
    sx[0] = ax0; sy[0] = ay0; ex[0] = ax1; ey[0] = ay1; px[0] = bx0; py[0] = by0;
    sx[1] = ax0; sy[1] = ay0; ex[1] = ax1; ey[1] = ay1; px[1] = bx1; py[1] = by1;
    sx[2] = bx0; sy[2] = by0; ex[2] = bx1; ey[2] = by1; px[2] = ax0; py[2] = ay0;
    sx[3] = bx0; sy[3] = by0; ex[3] = bx1; ey[3] = by1; px[3] = ax1; py[3] = ay1;
    for (int k = 0; k < N; k++) begin
      ux_d[k] = ex[k] - sx[k];
      uy_d[k] = ey[k] - sy[k];
      vx_d[k] = px[k] - sx[k];
      vy_d[k] = py[k] - sy[k];
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      lhs_d[k] = seg_isect_pkg::prod_t'(ux_q[k]) * seg_isect_pkg::prod_t'(vy_q[k]);
      rhs_d[k] = seg_isect_pkg::prod_t'(uy_q[k]) * seg_isect_pkg::prod_t'(vx_q[k]);
      dxx_d[k] = seg_isect_pkg::prod_t'(ux_q[k]) * seg_isect_pkg::prod_t'(vx_q[k]);
      dyy_d[k] = seg_isect_pkg::prod_t'(uy_q[k]) * seg_isect_pkg::prod_t'(vy_q[k]);
      uxx_d[k] = seg_isect_pkg::prod_t'(ux_q[k]) * seg_isect_pkg::prod_t'(ux_q[k]);
      uyy_d[k] = seg_isect_pkg::prod_t'(uy_q[k]) * seg_isect_pkg::prod_t'(uy_q[k]);
      vxx_d[k] = seg_isect_pkg::prod_t'(vx_q[k]) * seg_isect_pkg::prod_t'(vx_q[k]);
      vyy_d[k] = seg_isect_pkg::prod_t'(vy_q[k]) * seg_isect_pkg::prod_t'(vy_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      cross_d[k] = seg_isect_pkg::sum_t'(lhs_q[k]) - seg_isect_pkg::sum_t'(rhs_q[k]);
      dot_d[k]   = seg_isect_pkg::sum_t'(dxx_q[k]) + seg_isect_pkg::sum_t'(dyy_q[k]);
      lu_d[k]    = seg_isect_pkg::sum_t'(uxx_q[k]) + seg_isect_pkg::sum_t'(uyy_q[k]);
      lv_d[k]    = seg_isect_pkg::sum_t'(vxx_q[k]) + seg_isect_pkg::sum_t'(vyy_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (cross_q[k] > 0) begin
        code_d[k] = seg_isect_pkg::TURN_CCW;
      end else if (cross_q[k] < 0) begin
        code_d[k] = seg_isect_pkg::TURN_CW;
      end else if (dot_q[k] < 0) begin
        code_d[k] = seg_isect_pkg::TURN_BACK;
      end else if (lu_q[k] < lv_q[k]) begin
        code_d[k] = seg_isect_pkg::TURN_FRONT;
      end else begin
        code_d[k] = seg_isect_pkg::TURN_ON;
      end
    end
  end

  assign meet_d = seg_isect_pkg::pair_straddles(code_q[0], code_q[1]) &&
                  seg_isect_pkg::pair_straddles(code_q[2], code_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < N; k++) begin
        ux_q[k]       <= ux_d[k];
        uy_q[k]       <= uy_d[k];
        vx_q[k]       <= vx_d[k];
        vy_q[k]       <= vy_d[k];
        lhs_q[k]      <= lhs_d[k];
        rhs_q[k]      <= rhs_d[k];
        dxx_q[k]      <= dxx_d[k];
        dyy_q[k]      <= dyy_d[k];
        uxx_q[k]      <= uxx_d[k];
        uyy_q[k]      <= uyy_d[k];
        vxx_q[k]      <= vxx_d[k];
        vyy_q[k]      <= vyy_d[k];
        cross_q[k]    <= cross_d[k];
        dot_q[k]      <= dot_d[k];
        lu_q[k]       <= lu_d[k];
        lv_q[k]       <= lv_d[k];
        code_q[k]     <= code_d[k];
        out_code_q[k] <= code_q[k];
      end
      meet_q <= meet_d;
    end
  end

  assign out_valid_o     = v5_q;
  assign segments_meet_o = meet_q;
  assign turn_a_bstart_o = out_code_q[0];
  assign turn_a_bend_o   = out_code_q[1];
  assign turn_b_astart_o = out_code_q[2];
  assign turn_b_aend_o   = out_code_q[3];

endmodule
